[rtl/dmdt_pkg.sv]
`timescale 1ns / 1ps
package dmdt_pkg;

  // field and register widths
  localparam int COUNT_WIDTH_DEF = 16;
  localparam int TARGET_W        = 16;
  localparam int GAIN_W          = 8;
  localparam int LIMIT_W         = 12;
  localparam int INT_W           = 13;
  localparam int LINE_ERR_W      = 2;
  localparam int CFG_ADDR_W      = 5;
  localparam int CFG_DATA_W      = 32;
  localparam int TRIM_W          = 32;

  // register reset values
  localparam logic [TARGET_W-1:0] RST_DEFAULT_TARGET = 16'd1300;
  localparam logic [GAIN_W-1:0]   RST_ENC_GAIN_P     = 8'd3;
  localparam logic [GAIN_W-1:0]   RST_ENC_GAIN_I     = 8'd1;
  localparam logic [LIMIT_W-1:0]  RST_ENC_INT_LIMIT  = 12'd100;
  localparam logic [GAIN_W-1:0]   RST_LINE_GAIN_P    = 8'd50;
  localparam logic [GAIN_W-1:0]   RST_LINE_GAIN_I    = 8'd2;
  localparam logic [LIMIT_W-1:0]  RST_LINE_INT_LIMIT = 12'd100;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_LEFT  = 3'd1,
    OP_RIGHT = 3'd2,
    OP_LINE  = 3'd3,
    OP_STOP  = 3'd4,
    OP_START = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_ENC_FWD  = 3'd1,
    MODE_ENC_REV  = 3'd2,
    MODE_LINE_FWD = 3'd3,
    MODE_LINE_REV = 3'd4,
    MODE_TURN     = 3'd5
  } mode_t;

  // highest valid mode request (turn)
  localparam logic [2:0] REQ_TURN = 3'd4;

  typedef enum logic [2:0] {
    REG_DEFAULT_TARGET = 3'd0,
    REG_ENC_GAIN_P     = 3'd1,
    REG_ENC_GAIN_I     = 3'd2,
    REG_ENC_INT_LIMIT  = 3'd3,
    REG_LINE_GAIN_P    = 3'd4,
    REG_LINE_GAIN_I    = 3'd5,
    REG_LINE_INT_LIMIT = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [TARGET_W-1:0] default_target;
    logic [GAIN_W-1:0]   enc_gain_p;
    logic [GAIN_W-1:0]   enc_gain_i;
    logic [LIMIT_W-1:0]  enc_int_limit;
    logic [GAIN_W-1:0]   line_gain_p;
    logic [GAIN_W-1:0]   line_gain_i;
    logic [LIMIT_W-1:0]  line_int_limit;
  } cfg_t;

  typedef struct packed {
    logic trim_valid;
    logic reverse;
    logic done_res;
  } res_flags_t;

endpackage

[rtl/dmdt_cfg.sv]
`timescale 1ns / 1ps
module dmdt_cfg
  import dmdt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.default_target <= RST_DEFAULT_TARGET;
      cfg_r.enc_gain_p     <= RST_ENC_GAIN_P;
      cfg_r.enc_gain_i     <= RST_ENC_GAIN_I;
      cfg_r.enc_int_limit  <= RST_ENC_INT_LIMIT;
      cfg_r.line_gain_p    <= RST_LINE_GAIN_P;
      cfg_r.line_gain_i    <= RST_LINE_GAIN_I;
      cfg_r.line_int_limit <= RST_LINE_INT_LIMIT;
    end else if (wr_en) begin
      case (idx)
        REG_DEFAULT_TARGET: cfg_r.default_target <= pwdata[TARGET_W-1:0];
        REG_ENC_GAIN_P:     cfg_r.enc_gain_p     <= pwdata[GAIN_W-1:0];
        REG_ENC_GAIN_I:     cfg_r.enc_gain_i     <= pwdata[GAIN_W-1:0];
        REG_ENC_INT_LIMIT:  cfg_r.enc_int_limit  <= pwdata[LIMIT_W-1:0];
        REG_LINE_GAIN_P:    cfg_r.line_gain_p    <= pwdata[GAIN_W-1:0];
        REG_LINE_GAIN_I:    cfg_r.line_gain_i    <= pwdata[GAIN_W-1:0];
        REG_LINE_INT_LIMIT: cfg_r.line_int_limit <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DEFAULT_TARGET: prdata = CFG_DATA_W'(cfg_r.default_target);
      REG_ENC_GAIN_P:     prdata = CFG_DATA_W'(cfg_r.enc_gain_p);
      REG_ENC_GAIN_I:     prdata = CFG_DATA_W'(cfg_r.enc_gain_i);
      REG_ENC_INT_LIMIT:  prdata = CFG_DATA_W'(cfg_r.enc_int_limit);
      REG_LINE_GAIN_P:    prdata = CFG_DATA_W'(cfg_r.line_gain_p);
      REG_LINE_GAIN_I:    prdata = CFG_DATA_W'(cfg_r.line_gain_i);
      REG_LINE_INT_LIMIT: prdata = CFG_DATA_W'(cfg_r.line_int_limit);
      default:            prdata = '0;
    endcase
  end

endmodule

[rtl/dmdt_core.sv]
`timescale 1ns / 1ps
module dmdt_core
  import dmdt_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  localparam int ERR_W      = COUNT_WIDTH + 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cfg_t                     cfg,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0]               in_operation,
  input  logic [2:0]               in_mode_request,
  input  logic                     in_arm_distance_stop,
  input  logic [TARGET_W-1:0]      in_target_count,
  input  logic                     in_sensor_left,
  input  logic                     in_sensor_right,
  output logic                     pi_valid,
  input  logic                     pi_ready,
  output res_flags_t               pi_flags,
  output logic signed [ERR_W-1:0]  pi_err,
  output logic signed [INT_W-1:0]  pi_integ,
  output logic [GAIN_W-1:0]        pi_gain_p,
  output logic [GAIN_W-1:0]        pi_gain_i
);

  localparam int ENC_SUM_W  = ((ERR_W > INT_W) ? ERR_W : INT_W) + 1;
  localparam int LINE_SUM_W = INT_W + 1;
  localparam int CMP_W      = (COUNT_WIDTH > TARGET_W) ? COUNT_WIDTH : TARGET_W;

  // input register
  logic                  a_valid_r;
  logic [2:0]            a_op_r;
  logic [2:0]            a_mreq_r;
  logic                  a_arm_r;
  logic [TARGET_W-1:0]   a_tcount_r;
  logic                  a_sl_r;
  logic                  a_sr_r;
  logic                  a_go;

  // controller state
  mode_t                       mode_r, mode_nxt;
  logic                        armed_r, armed_nxt;
  logic [TARGET_W-1:0]         target_r, target_nxt;
  logic [COUNT_WIDTH-1:0]      left_r, left_nxt;
  logic [COUNT_WIDTH-1:0]      right_r, right_nxt;
  logic signed [INT_W-1:0]     enc_int_r, enc_int_nxt;
  logic signed [INT_W-1:0]     line_int_r, line_int_nxt;
  logic signed [LINE_ERR_W-1:0] last_err_r, last_err_nxt;

  // operand register toward the pi stage
  logic                    b_valid_r;
  res_flags_t              b_flags_r, b_flags_nxt;
  logic signed [ERR_W-1:0] b_err_r, b_err_nxt;
  logic signed [INT_W-1:0] b_int_r, b_int_nxt;
  logic [GAIN_W-1:0]       b_gp_r, b_gp_nxt;
  logic [GAIN_W-1:0]       b_gi_r, b_gi_nxt;

  // datapath
  logic [COUNT_WIDTH:0]          cnt_sum;
  logic                          reached;
  logic signed [ERR_W-1:0]       enc_err;
  logic signed [ENC_SUM_W-1:0]   enc_sum, enc_lim, enc_clamp;
  logic signed [LINE_ERR_W-1:0]  line_err;
  logic signed [LINE_SUM_W-1:0]  line_sum, line_lim, line_clamp;
  logic signed [INT_W-1:0]       line_new;
  logic                          clr;
  logic                          arm_set;

  assign a_go     = a_valid_r && (!b_valid_r || pi_ready);
  assign in_ready = !a_valid_r || a_go;

  assign pi_valid  = b_valid_r;
  assign pi_flags  = b_flags_r;
  assign pi_err    = b_err_r;
  assign pi_integ  = b_int_r;
  assign pi_gain_p = b_gp_r;
  assign pi_gain_i = b_gi_r;

  always_comb begin
    // average count against target
    cnt_sum = {1'b0, left_r} + {1'b0, right_r};
    reached = CMP_W'(cnt_sum[COUNT_WIDTH:1]) >= CMP_W'(target_r);

    // encoder loop integral
    enc_err = $signed({1'b0, left_r}) - $signed({1'b0, right_r});
    enc_sum = ENC_SUM_W'(enc_int_r) + ENC_SUM_W'(enc_err);
    enc_lim = $signed(ENC_SUM_W'(cfg.enc_int_limit));
    if (enc_sum > enc_lim) begin
      enc_clamp = enc_lim;
    end else if (enc_sum < -enc_lim) begin
      enc_clamp = -enc_lim;
    end else begin
      enc_clamp = enc_sum;
    end

    // line error, holding the last one when both sensors read dark
    case ({a_sl_r, a_sr_r})
      2'b01:   line_err = 2'sd1;
      2'b10:   line_err = -2'sd1;
      2'b11:   line_err = 2'sd0;
      default: line_err = last_err_r;
    endcase
    line_sum = LINE_SUM_W'(line_int_r) + LINE_SUM_W'(line_err);
    line_lim = $signed(LINE_SUM_W'(cfg.line_int_limit));
    if (line_sum > line_lim) begin
      line_clamp = line_lim;
    end else if (line_sum < -line_lim) begin
      line_clamp = -line_lim;
    end else begin
      line_clamp = line_sum;
    end
    line_new = (line_err != 2'sd0) ? line_clamp[INT_W-1:0] : line_int_r;

    mode_nxt     = mode_r;
    armed_nxt    = armed_r;
    target_nxt   = target_r;
    left_nxt     = left_r;
    right_nxt    = right_r;
    enc_int_nxt  = enc_int_r;
    line_int_nxt = line_int_r;
    last_err_nxt = last_err_r;
    b_flags_nxt  = '0;
    b_err_nxt    = enc_err;
    b_int_nxt    = enc_clamp[INT_W-1:0];
    b_gp_nxt     = cfg.enc_gain_p;
    b_gi_nxt     = cfg.enc_gain_i;
    clr          = 1'b0;
    arm_set      = 1'b0;

    case (op_t'(a_op_r))
      OP_TICK: begin
        if (mode_r != MODE_IDLE) begin
          if (mode_r == MODE_ENC_FWD || mode_r == MODE_ENC_REV) begin
            enc_int_nxt            = enc_clamp[INT_W-1:0];
            b_flags_nxt.trim_valid = 1'b1;
            b_flags_nxt.reverse    = (mode_r == MODE_ENC_REV);
          end
          if (armed_r && reached) begin
            b_flags_nxt.done_res = 1'b1;
            clr                  = 1'b1;
            mode_nxt             = MODE_IDLE;
          end
        end
      end
      OP_LEFT: begin
        if (left_r != '1) begin
          left_nxt = left_r + 1'b1;
        end
      end
      OP_RIGHT: begin
        if (right_r != '1) begin
          right_nxt = right_r + 1'b1;
        end
      end
      OP_LINE: begin
        if (mode_r == MODE_LINE_FWD || mode_r == MODE_LINE_REV) begin
          line_int_nxt           = line_new;
          last_err_nxt           = line_err;
          b_err_nxt              = ERR_W'(line_err);
          b_int_nxt              = line_new;
          b_gp_nxt               = cfg.line_gain_p;
          b_gi_nxt               = cfg.line_gain_i;
          b_flags_nxt.trim_valid = 1'b1;
          b_flags_nxt.reverse    = (mode_r == MODE_LINE_REV);
        end
      end
      OP_STOP: begin
        clr      = 1'b1;
        mode_nxt = MODE_IDLE;
      end
      OP_START: begin
        if (a_mreq_r <= REQ_TURN) begin
          clr      = 1'b1;
          mode_nxt = mode_t'(a_mreq_r + 3'd1);
          arm_set  = a_arm_r || (a_mreq_r == REQ_TURN);
        end
      end
      default: ;
    endcase

    if (clr) begin
      left_nxt     = '0;
      right_nxt    = '0;
      enc_int_nxt  = '0;
      line_int_nxt = '0;
      armed_nxt    = 1'b0;
      target_nxt   = cfg.default_target;
    end
    if (arm_set) begin
      armed_nxt  = 1'b1;
      target_nxt = (a_tcount_r != '0) ? a_tcount_r : cfg.default_target;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ready) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_op_r     <= in_operation;
      a_mreq_r   <= in_mode_request;
      a_arm_r    <= in_arm_distance_stop;
      a_tcount_r <= in_target_count;
      a_sl_r     <= in_sensor_left;
      a_sr_r     <= in_sensor_right;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_IDLE;
      armed_r    <= 1'b0;
      target_r   <= RST_DEFAULT_TARGET;
      left_r     <= '0;
      right_r    <= '0;
      enc_int_r  <= '0;
      line_int_r <= '0;
      last_err_r <= '0;
    end else if (a_go) begin
      mode_r     <= mode_nxt;
      armed_r    <= armed_nxt;
      target_r   <= target_nxt;
      left_r     <= left_nxt;
      right_r    <= right_nxt;
      enc_int_r  <= enc_int_nxt;
      line_int_r <= line_int_nxt;
      last_err_r <= last_err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (!b_valid_r || pi_ready) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_go) begin
      b_flags_r <= b_flags_nxt;
      b_err_r   <= b_err_nxt;
      b_int_r   <= b_int_nxt;
      b_gp_r    <= b_gp_nxt;
      b_gi_r    <= b_gi_nxt;
    end
  end

endmodule

[rtl/dmdt_pi.sv]
`timescale 1ns / 1ps
module dmdt_pi
  import dmdt_pkg::*;
#(
  parameter int ERR_W = COUNT_WIDTH_DEF + 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     pi_valid,
  output logic                     pi_ready,
  input  res_flags_t               pi_flags,
  input  logic signed [ERR_W-1:0]  pi_err,
  input  logic signed [INT_W-1:0]  pi_integ,
  input  logic [GAIN_W-1:0]        pi_gain_p,
  input  logic [GAIN_W-1:0]        pi_gain_i,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_trim_valid,
  output logic signed [TRIM_W-1:0] out_trim,
  output logic                     out_reverse,
  output logic                     out_done_res
);

  localparam int PP_W  = ERR_W + GAIN_W + 1;
  localparam int PI_W  = INT_W + GAIN_W + 1;
  localparam int SUM_W = ((PP_W > PI_W) ? PP_W : PI_W) + 1;

  logic signed [PP_W-1:0]   prod_p;
  logic signed [PI_W-1:0]   prod_i;
  logic signed [SUM_W-1:0]  pi_sum;
  logic signed [TRIM_W-1:0] sat_trim;
  logic signed [TRIM_W-1:0] trim_nxt;

  logic                     c_valid_r;
  res_flags_t               c_flags_r;
  logic signed [TRIM_W-1:0] c_trim_r;

  assign prod_p = $signed({1'b0, pi_gain_p}) * pi_err;
  assign prod_i = $signed({1'b0, pi_gain_i}) * pi_integ;
  assign pi_sum = SUM_W'(prod_p) + SUM_W'(prod_i);

  generate
    if (SUM_W > TRIM_W) begin : g_sat
      logic [SUM_W-TRIM_W:0] hi_bits;
      assign hi_bits = pi_sum[SUM_W-1:TRIM_W-1];
      always_comb begin
        if ((&hi_bits) || !(|hi_bits)) begin
          sat_trim = pi_sum[TRIM_W-1:0];
        end else if (pi_sum[SUM_W-1]) begin
          sat_trim = {1'b1, {(TRIM_W-1){1'b0}}};
        end else begin
          sat_trim = {1'b0, {(TRIM_W-1){1'b1}}};
        end
      end
    end else begin : g_ext
      assign sat_trim = TRIM_W'(pi_sum);
    end
  endgenerate

  assign trim_nxt = pi_flags.trim_valid ? sat_trim : '0;
  assign pi_ready = !c_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (pi_ready) begin
      c_valid_r <= pi_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pi_valid && pi_ready) begin
      c_flags_r <= pi_flags;
      c_trim_r  <= trim_nxt;
    end
  end

  assign out_valid      = c_valid_r;
  assign out_trim_valid = c_flags_r.trim_valid;
  assign out_trim       = c_trim_r;
  assign out_reverse    = c_flags_r.reverse;
  assign out_done_res   = c_flags_r.done_res;

endmodule

[rtl/dual_mode_drive_trim_pi.sv]
`timescale 1ns / 1ps
// channel   | handshake            | payload
// ----------+----------------------+---------------------------------------------
// input     | in_valid / in_ready  | operation, mode_request, arm_distance_stop,
//           |                      | target_count, sensor_left, sensor_right
// result    | out_valid/ out_ready | trim_valid, trim, reverse, done_res
// config    | psel/penable/pwrite  | paddr (reg i at 4*i), pwdata, prdata, pready
//
// one item per cycle sustained while out_ready holds; items pass through the
// input register, operand register and result register; the limit is the single
// state update pass in the core stage, which every item goes through in order
// rst_n is synchronous: it empties the pipeline, puts the controller in idle and
// loads the register reset values; no clearing pass is needed
// a stalled result holds in the result register while the earlier stages keep
// filling, so in_ready drops only once all three stages hold items
`default_nettype none
module dual_mode_drive_trim_pi
  import dmdt_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // input item channel
  input  wire logic                     in_valid,
  output      logic                     in_ready,
  input  wire logic [2:0]               in_operation,
  input  wire logic [2:0]               in_mode_request,
  input  wire logic                     in_arm_distance_stop,
  input  wire logic [TARGET_W-1:0]      in_target_count,
  input  wire logic                     in_sensor_left,
  input  wire logic                     in_sensor_right,
  // result item channel
  output      logic                     out_valid,
  input  wire logic                     out_ready,
  output      logic                     out_trim_valid,
  output      logic signed [TRIM_W-1:0] out_trim,
  output      logic                     out_reverse,
  output      logic                     out_done_res,
  // register port
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [CFG_ADDR_W-1:0]    paddr,
  input  wire logic [CFG_DATA_W-1:0]    pwdata,
  output      logic [CFG_DATA_W-1:0]    prdata,
  output      logic                     pready
);

  localparam int ERR_W = COUNT_WIDTH + 1;

  cfg_t                    cfg;
  logic                    pi_valid;
  logic                    pi_ready;
  res_flags_t              pi_flags;
  logic signed [ERR_W-1:0] pi_err;
  logic signed [INT_W-1:0] pi_integ;
  logic [GAIN_W-1:0]       pi_gain_p;
  logic [GAIN_W-1:0]       pi_gain_i;

  // gains, limits and default target; user must write only with no item in flight, unchecked
  dmdt_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input register, mode/count/integral state and the per-item update;
  // hands the pi operands of the item to the next stage
  dmdt_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_operation         (in_operation),
    .in_mode_request      (in_mode_request),
    .in_arm_distance_stop (in_arm_distance_stop),
    .in_target_count      (in_target_count),
    .in_sensor_left       (in_sensor_left),
    .in_sensor_right      (in_sensor_right),
    .pi_valid             (pi_valid),
    .pi_ready             (pi_ready),
    .pi_flags             (pi_flags),
    .pi_err               (pi_err),
    .pi_integ             (pi_integ),
    .pi_gain_p            (pi_gain_p),
    .pi_gain_i            (pi_gain_i)
  );

  // gain multiplies, sum, and sign extension or 32-bit saturation into the result register
  dmdt_pi #(
    .ERR_W (ERR_W)
  ) u_pi (
    .clk            (clk),
    .rst_n          (rst_n),
    .pi_valid       (pi_valid),
    .pi_ready       (pi_ready),
    .pi_flags       (pi_flags),
    .pi_err         (pi_err),
    .pi_integ       (pi_integ),
    .pi_gain_p      (pi_gain_p),
    .pi_gain_i      (pi_gain_i),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_trim_valid (out_trim_valid),
    .out_trim       (out_trim),
    .out_reverse    (out_reverse),
    .out_done_res   (out_done_res)
  );

endmodule
`default_nettype wire

[rtl/dmdt_checker.sv]
`timescale 1ns / 1ps
module dmdt_checker
  import dmdt_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic                     out_trim_valid,
  input logic signed [TRIM_W-1:0] out_trim,
  input logic                     out_reverse,
  input logic                     out_done_res,
  input logic                     psel,
  input logic                     penable,
  input logic                     pready
);

  // a result waiting for the sink keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_trim) &&
      $stable(out_trim_valid) && $stable(out_reverse) && $stable(out_done_res))
    else $error("result changed while stalled");

  // no trim means zero trim and forward direction
  a_no_trim_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_trim_valid |-> out_trim == '0 && !out_reverse)
    else $error("trim or reverse set without a trim");

  // with the result register empty the pipeline always has room
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // reset empties the result side
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // register port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable |-> pready)
    else $error("register access stalled");

endmodule

bind dual_mode_drive_trim_pi dmdt_checker u_dmdt_checker (.*);
